// ===== hdl/ront_pkg.sv =====
// ----------------------------------------------------------------------------
// ront_pkg: shared types for the ring ordered node table
// command and result words, item kinds, status codes and default sizes
// ----------------------------------------------------------------------------
package ront_pkg;

    localparam int DEFAULT_MAX_NODES = 32;
    localparam int DEFAULT_ID_BITS   = 16;

    localparam int NODE_ID_W = 16;
    localparam int POS_W     = 5;
    localparam int DIST_W    = 5;
    localparam int COUNT_W   = 6;

    typedef enum logic [1:0] {
        KIND_CLEAR  = 2'd0,
        KIND_INSERT = 2'd1,
        KIND_FIND   = 2'd2,
        KIND_READ   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_FULL      = 2'd1,
        STATUS_NOT_FOUND = 2'd2,
        STATUS_RANGE     = 2'd3
    } status_t;

    typedef struct packed {
        kind_t                 kind;
        logic [NODE_ID_W-1:0]  node_id;
        logic [POS_W-1:0]      position;
    } cmd_t;

    typedef struct packed {
        status_t               status;
        logic [DIST_W-1:0]     distance;
        logic [NODE_ID_W-1:0]  found_id;
        logic [COUNT_W-1:0]    node_count;
    } result_t;

endpackage

// ===== hdl/ront_cell.sv =====
// ----------------------------------------------------------------------------
// ront_cell: one slot of the sorted table
// holds one ring key, decides locally whether an insert shifts it and takes
// the neighbor's key or the new key, and flags a match for lookups
// ----------------------------------------------------------------------------
module ront_cell #(
    parameter int KEY_BITS = ront_pkg::DEFAULT_ID_BITS
) (
    input  logic                clk,
    input  logic                ins_en,
    input  logic                occupied,
    input  logic [KEY_BITS-1:0] new_key,
    input  logic [KEY_BITS-1:0] query_key,
    input  logic                prev_shift,
    input  logic [KEY_BITS-1:0] prev_key,
    output logic [KEY_BITS-1:0] key,
    output logic                shift,
    output logic                match
);

    logic [KEY_BITS-1:0] key_reg;
    logic [KEY_BITS-1:0] key_next;

    // strictly greater keeps equal keys in arrival order
    assign shift = !occupied || (key_reg > new_key);
    assign match = occupied && (key_reg == query_key);
    assign key   = key_reg;

    always_comb
    begin
        key_next = key_reg;
        if (ins_en && shift)
        begin
            key_next = prev_shift ? prev_key : new_key;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

endmodule

// ===== hdl/ront_first_match.sv =====
// ----------------------------------------------------------------------------
// ront_first_match: lowest set bit of the registered match vector
// isolates the first hit and encodes its position
// ----------------------------------------------------------------------------
module ront_first_match #(
    parameter int MAX_NODES = ront_pkg::DEFAULT_MAX_NODES,
    localparam int IDX_W    = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1
) (
    input  logic [MAX_NODES-1:0] hits,
    output logic                 found,
    output logic [IDX_W-1:0]     index
);

    logic [MAX_NODES-1:0] lowest;

    assign lowest = hits & (~hits + MAX_NODES'(1));
    assign found  = |hits;

    always_comb
    begin
        index = '0;
        for (int i = 0; i < MAX_NODES; i++)
        begin
            if (lowest[i])
            begin
                index = index | IDX_W'(i);
            end
        end
    end

endmodule

// ===== hdl/ring_ordered_node_table.sv =====
// ----------------------------------------------------------------------------
// ring_ordered_node_table: node ids kept sorted by clockwise ring distance
// table of ids ordered by (id - origin) mod 2^ID_BITS in a row of cells
// ----------------------------------------------------------------------------
// usage
//   command channel: a word on cmd is taken at a clock edge with start high
//   and busy low. busy stays low, so one word can be taken every cycle.
//   result channel: each command gives exactly one result word, shown on
//   result with result_valid high for one cycle, the cycle after the
//   command was taken. the receiver cannot stall; nothing is held back.
//   configuration: cfg_data is written into the local id register when
//   cfg_valid and cfg_ready are high. cfg_ready is always high. the local id
//   becomes the ring origin only at the next clear command.
//   datapath: insert is one compare per cell against the broadcast key plus a
//   one-step shift to the neighbor; find registers the per-cell match
//   vector and a priority encoder picks the first hit in the result cycle;
//   read selects one cell by position.
//   reset: the table is empty and the origin and local id are zero. no
//   clearing pass is needed; stored slots beyond the count are never used.
// ----------------------------------------------------------------------------
module ring_ordered_node_table #(
    parameter int MAX_NODES = ront_pkg::DEFAULT_MAX_NODES,
    parameter int ID_BITS   = ront_pkg::DEFAULT_ID_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  ront_pkg::cmd_t                      cmd,
    output logic                                result_valid,
    output ront_pkg::result_t                   result,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ront_pkg::NODE_ID_W-1:0]      cfg_data
);

    import ront_pkg::*;

    localparam int CNT_W  = $clog2(MAX_NODES + 1);
    localparam int IDX_W  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int RD_N   = (MAX_NODES < (1 << POS_W)) ? MAX_NODES : (1 << POS_W);

    logic                  accept;
    logic                  full;
    logic [ID_BITS-1:0]    cmd_id;
    logic [ID_BITS-1:0]    cmd_key;
    logic                  ins_en;

    logic [NODE_ID_W-1:0]  local_id_reg;
    logic [ID_BITS-1:0]    origin_reg;
    logic [ID_BITS-1:0]    origin_next;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;

    logic [ID_BITS-1:0]    cell_key   [MAX_NODES];
    logic [MAX_NODES-1:0]  cell_shift;
    logic [MAX_NODES-1:0]  cell_match;
    logic [MAX_NODES-1:0]  cell_occ;

    logic                  rd_ok;
    logic [ID_BITS-1:0]    rd_key;

    logic                  res_vld_reg;
    kind_t                 kind_reg;
    logic                  full_reg;
    logic                  rd_ok_reg;
    logic [ID_BITS-1:0]    rd_id_reg;
    logic [MAX_NODES-1:0]  match_reg;

    logic                  hit_found;
    logic [IDX_W-1:0]      hit_index;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    assign full    = (count_reg >= CNT_W'(MAX_NODES));
    assign cmd_id  = ID_BITS'(cmd.node_id);
    assign cmd_key = cmd_id - origin_reg;
    assign ins_en  = accept && (cmd.kind == KIND_INSERT) && !full;

    // row of cells, each takes its left neighbor's key or the new key when an insert shifts it
    for (genvar i = 0; i < MAX_NODES; i++)
    begin : g_cell
        assign cell_occ[i] = (count_reg > CNT_W'(i));
        if (i == 0)
        begin : g_head
            ront_cell #(.KEY_BITS(ID_BITS)) u_cell (
                .clk        (clk),
                .ins_en     (ins_en),
                .occupied   (cell_occ[i]),
                .new_key    (cmd_key),
                .query_key  (cmd_key),
                .prev_shift (1'b0),
                .prev_key   (cmd_key),
                .key        (cell_key[i]),
                .shift      (cell_shift[i]),
                .match      (cell_match[i])
            );
        end
        else
        begin : g_body
            ront_cell #(.KEY_BITS(ID_BITS)) u_cell (
                .clk        (clk),
                .ins_en     (ins_en),
                .occupied   (cell_occ[i]),
                .new_key    (cmd_key),
                .query_key  (cmd_key),
                .prev_shift (cell_shift[i-1]),
                .prev_key   (cell_key[i-1]),
                .key        (cell_key[i]),
                .shift      (cell_shift[i]),
                .match      (cell_match[i])
            );
        end
    end

    // position read, only the first slots are reachable by the position field
    assign rd_ok = (CMP_W'(cmd.position) < CMP_W'(count_reg));

    always_comb
    begin
        rd_key = '0;
        for (int i = 0; i < RD_N; i++)
        begin
            if (cmd.position == POS_W'(i))
            begin
                rd_key = rd_key | cell_key[i];
            end
        end
    end

    always_comb
    begin
        count_next  = count_reg;
        origin_next = origin_reg;
        if (accept)
        begin
            unique case (cmd.kind)
                KIND_CLEAR:
                begin
                    count_next  = '0;
                    origin_next = ID_BITS'(local_id_reg);
                end
                KIND_INSERT:
                begin
                    if (!full)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_id_reg <= '0;
            origin_reg   <= '0;
            count_reg    <= '0;
            res_vld_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                local_id_reg <= cfg_data;
            end
            origin_reg  <= origin_next;
            count_reg   <= count_next;
            res_vld_reg <= accept;
        end
    end

    // result word fields captured with the command
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg  <= cmd.kind;
            full_reg  <= full;
            rd_ok_reg <= rd_ok;
            rd_id_reg <= rd_key + origin_reg;
            match_reg <= cell_match;
        end
    end

    ront_first_match #(.MAX_NODES(MAX_NODES)) u_first_match (
        .hits  (match_reg),
        .found (hit_found),
        .index (hit_index)
    );

    assign result_valid = res_vld_reg;

    always_comb
    begin
        result            = '0;
        result.node_count = COUNT_W'(count_reg);
        unique case (kind_reg)
            KIND_CLEAR:
            begin
                result.status = STATUS_OK;
            end
            KIND_INSERT:
            begin
                result.status = full_reg ? STATUS_FULL : STATUS_OK;
            end
            KIND_FIND:
            begin
                if (hit_found)
                begin
                    result.status   = STATUS_OK;
                    result.distance = DIST_W'(hit_index);
                end
                else
                begin
                    result.status = STATUS_NOT_FOUND;
                end
            end
            KIND_READ:
            begin
                if (rd_ok_reg)
                begin
                    result.status   = STATUS_OK;
                    result.found_id = NODE_ID_W'(rd_id_reg);
                end
                else
                begin
                    result.status = STATUS_RANGE;
                end
            end
            default:
            begin
                result.status = STATUS_OK;
            end
        endcase
    end

endmodule

// ===== verif/tb_ring_ordered_node_table.sv =====
// ----------------------------------------------------------------------------
// tb_ring_ordered_node_table: self-checking bench for the ring ordered table
// drives clear, insert, find and read commands plus local id writes, keeps
// a shadow of the sorted table and checks every result word field by field
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_ring_ordered_node_table;

    import ront_pkg::*;

    class ring_table_board;
        localparam int DEPTH = DEFAULT_MAX_NODES;

        logic [NODE_ID_W-1:0] ids [DEPTH];
        int                   entries;
        logic [NODE_ID_W-1:0] local_id;
        logic [NODE_ID_W-1:0] origin;
        result_t              owed_results [$];
        int                   mismatches;
        int                   checked;
        int                   status_tally [4];

        function new();
            entries    = 0;
            local_id   = '0;
            origin     = '0;
            mismatches = 0;
            checked    = 0;
            foreach (status_tally[i])
                status_tally[i] = 0;
        endfunction

        function logic [NODE_ID_W-1:0] ring_key(logic [NODE_ID_W-1:0] id);
            return id - origin;
        endfunction

        function void set_local(logic [NODE_ID_W-1:0] value);
            local_id = value;
        endfunction

        // work out the result word of one accepted command and update the shadow
        function void apply_command(cmd_t word);
            result_t              r;
            logic [NODE_ID_W-1:0] key;
            int                   at;
            int                   i;
            r        = '0;
            r.status = STATUS_OK;
            case (word.kind)
                KIND_CLEAR:
                begin
                    entries = 0;
                    origin  = local_id;
                end
                KIND_INSERT:
                begin
                    if (entries >= DEPTH)
                        r.status = STATUS_FULL;
                    else
                    begin
                        key = ring_key(word.node_id);
                        at  = 0;
                        // equal keys keep arrival order
                        while (at < entries && ring_key(ids[at]) <= key)
                            at++;
                        for (i = entries; i > at; i--)
                            ids[i] = ids[i-1];
                        ids[at] = word.node_id;
                        entries++;
                    end
                end
                KIND_FIND:
                begin
                    at = -1;
                    for (i = 0; i < entries; i++)
                        if (at < 0 && ids[i] == word.node_id)
                            at = i;
                    if (at < 0)
                        r.status = STATUS_NOT_FOUND;
                    else
                        r.distance = at[DIST_W-1:0];
                end
                default:
                begin
                    if (int'(word.position) < entries)
                        r.found_id = ids[word.position];
                    else
                        r.status = STATUS_RANGE;
                end
            endcase
            r.node_count = entries[COUNT_W-1:0];
            status_tally[int'(r.status)]++;
            owed_results.push_back(r);
        endfunction

        function void compare_result(result_t got);
            result_t exp;
            if (owed_results.size() == 0)
            begin
                $error("result word with no command pending: %h", got);
                mismatches++;
                return;
            end
            exp = owed_results.pop_front();
            checked++;
            if (got.status !== exp.status)
            begin
                $error("status: expected %0d, got %0d", exp.status, got.status);
                mismatches++;
            end
            if (got.distance !== exp.distance)
            begin
                $error("distance: expected %0d, got %0d", exp.distance, got.distance);
                mismatches++;
            end
            if (got.found_id !== exp.found_id)
            begin
                $error("found_id: expected %h, got %h", exp.found_id, got.found_id);
                mismatches++;
            end
            if (got.node_count !== exp.node_count)
            begin
                $error("node_count: expected %0d, got %0d",
                       exp.node_count, got.node_count);
                mismatches++;
            end
        endfunction
    endclass

    localparam int RANDOM_ITEMS = 1850;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    cmd_t                 cmd;
    logic                 result_valid;
    result_t              result;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [NODE_ID_W-1:0] cfg_data;

    ring_table_board      board;
    logic [NODE_ID_W-1:0] episode_ids [$];
    int                   sent;
    int                   cfg_writes;
    bit                   steady;

    ring_ordered_node_table dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // sample on the edge: result first, then the newly taken command word
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid)
                board.compare_result(result);
            if (start && !busy)
                board.apply_command(cmd);
            if (cfg_valid && cfg_ready)
                board.set_local(cfg_data);
        end
    end

    task automatic issue(kind_t k, logic [NODE_ID_W-1:0] id, logic [POS_W-1:0] pos);
        cmd_t word;
        begin
            word.kind     = k;
            word.node_id  = id;
            word.position = pos;
            while (!steady && $urandom_range(0, 99) < 8)
            begin
                start <= 1'b0;
                @(posedge clk);
            end
            start <= 1'b1;
            cmd   <= word;
            do @(posedge clk); while (busy);
            sent++;
            steady = (sent >= 700 && sent < 1100);
        end
    endtask

    // local id only changes with the table quiet
    task automatic load_local_id(logic [NODE_ID_W-1:0] value);
        begin
            start <= 1'b0;
            @(posedge clk);
            while (board.owed_results.size() != 0)
                @(posedge clk);
            @(posedge clk);
            while (!steady && $urandom_range(0, 99) < 8)
                @(posedge clk);
            cfg_valid <= 1'b1;
            cfg_data  <= value;
            do @(posedge clk); while (!cfg_ready);
            cfg_valid <= 1'b0;
            cfg_writes++;
        end
    endtask

    function automatic logic [NODE_ID_W-1:0] pick_id();
        logic [NODE_ID_W-1:0] v;
        case ($urandom_range(0, 9))
            0: v = '0;
            1: v = '1;
            // right around the origin, where the ring wraps
            2: v = board.origin + NODE_ID_W'($urandom_range(0, 2)) - 1'b1;
            3, 4:
            begin
                if (episode_ids.size() != 0)
                    v = episode_ids[$urandom_range(0, episode_ids.size() - 1)];
                else
                    v = NODE_ID_W'($urandom);
            end
            default: v = NODE_ID_W'($urandom);
        endcase
        return v;
    endfunction

    function automatic logic [NODE_ID_W-1:0] pick_local();
        logic [NODE_ID_W-1:0] v;
        case ($urandom_range(0, 4))
            0: v = '0;
            1: v = '1;
            2: v = 16'h8000;
            default: v = NODE_ID_W'($urandom);
        endcase
        return v;
    endfunction

    initial
    begin
        int                   target;
        int                   inserted;
        int                   roll;
        int                   wait_cycles;
        logic [NODE_ID_W-1:0] id;
        logic [POS_W-1:0]     pos;

        board      = new();
        sent       = 0;
        cfg_writes = 0;
        steady     = 1'b0;
        rst_n     <= 1'b0;
        start     <= 1'b0;
        cmd       <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table, both ends of the id range, duplicates, wrap order
        issue(KIND_READ,   16'h0000, 5'd0);
        issue(KIND_READ,   16'hFFFF, 5'd31);
        issue(KIND_FIND,   16'h0000, 5'd0);
        issue(KIND_INSERT, 16'hFFFF, 5'd0);
        issue(KIND_INSERT, 16'h0000, 5'd31);
        issue(KIND_INSERT, 16'h0000, 5'd0);
        issue(KIND_INSERT, 16'h8000, 5'd0);
        issue(KIND_READ,   16'h0000, 5'd0);
        issue(KIND_READ,   16'h0000, 5'd1);
        issue(KIND_READ,   16'h0000, 5'd2);
        issue(KIND_READ,   16'h0000, 5'd3);
        issue(KIND_READ,   16'h0000, 5'd4);
        issue(KIND_FIND,   16'hFFFF, 5'd0);
        // new local id must not move the origin before a clear
        load_local_id(16'hFFFF);
        issue(KIND_INSERT, 16'h0001, 5'd0);
        issue(KIND_READ,   16'h0000, 5'd2);
        issue(KIND_CLEAR,  16'hFFFF, 5'd31);
        issue(KIND_INSERT, 16'h0000, 5'd0);
        issue(KIND_INSERT, 16'hFFFF, 5'd0);
        issue(KIND_INSERT, 16'hFFFE, 5'd0);
        issue(KIND_FIND,   16'hFFFE, 5'd0);
        issue(KIND_READ,   16'h0000, 5'd0);
        issue(KIND_READ,   16'h0000, 5'd31);
        issue(KIND_FIND,   16'h1234, 5'd0);
        load_local_id(16'h0000);
        issue(KIND_CLEAR,  16'h0000, 5'd0);

        while (sent < RANDOM_ITEMS + 25)
        begin
            if ($urandom_range(0, 1) == 0)
                load_local_id(pick_local());
            if ($urandom_range(0, 9) < 8)
            begin
                issue(KIND_CLEAR, NODE_ID_W'($urandom), POS_W'($urandom_range(0, 31)));
                episode_ids.delete();
            end
            // some episodes run past a full table
            target   = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 40)
                                                   : $urandom_range(0, 20);
            inserted = 0;
            while (inserted < target && sent < RANDOM_ITEMS + 25)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 50)
                begin
                    id = pick_id();
                    issue(KIND_INSERT, id, POS_W'($urandom_range(0, 31)));
                    episode_ids.push_back(id);
                    inserted++;
                end
                else if (roll < 70)
                begin
                    if (episode_ids.size() != 0 && $urandom_range(0, 3) != 0)
                        id = episode_ids[$urandom_range(0, episode_ids.size() - 1)];
                    else
                        id = pick_id();
                    issue(KIND_FIND, id, POS_W'($urandom_range(0, 31)));
                end
                else if (roll < 92)
                begin
                    if (board.entries > 0 && $urandom_range(0, 4) != 0)
                        pos = POS_W'($urandom_range(0, board.entries - 1));
                    else
                        pos = POS_W'($urandom_range(0, 31));
                    issue(KIND_READ, NODE_ID_W'($urandom), pos);
                end
                else if (roll < 96)
                begin
                    issue(KIND_CLEAR, NODE_ID_W'($urandom), POS_W'($urandom_range(0, 31)));
                    episode_ids.delete();
                end
                else
                    issue(kind_t'($urandom_range(0, 3)), NODE_ID_W'($urandom),
                          POS_W'($urandom_range(0, 31)));
            end
        end

        start <= 1'b0;
        wait_cycles = 0;
        while (board.owed_results.size() != 0 && wait_cycles < 100)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (4) @(posedge clk);
        if (board.owed_results.size() != 0)
        begin
            $error("%0d result words never arrived", board.owed_results.size());
            board.mismatches++;
        end

        $display("%0d commands, %0d results checked, %0d local id writes",
                 sent, board.checked, cfg_writes);
        $display("status ok %0d, full %0d, not found %0d, out of range %0d",
                 board.status_tally[0], board.status_tally[1],
                 board.status_tally[2], board.status_tally[3]);
        if (board.mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #3_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
